// File: rtl/iuhb_pkg.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header builder package
// Shared types, constants and header word functions for the header builder.
// ----------------------------------------------------------------------------
package iuhb_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ADDRESS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDRESS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_PORT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_PORT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION_TOS_WORD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD      = 3'd5;

   localparam logic [15:0] VERSION_TOS_RESET = 16'h4500;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;

   // Word positions in a header run.
   localparam logic [3:0] W_FRAME_LEN = 4'd0;
   localparam logic [3:0] W_VER_TOS   = 4'd1;
   localparam logic [3:0] W_TOTAL_LEN = 4'd2;
   localparam logic [3:0] W_ID        = 4'd3;
   localparam logic [3:0] W_FLAGS     = 4'd4;
   localparam logic [3:0] W_TTL_PROTO = 4'd5;
   localparam logic [3:0] W_HDR_CSUM  = 4'd6;
   localparam logic [3:0] W_SRC_HI    = 4'd7;
   localparam logic [3:0] W_SRC_LO    = 4'd8;
   localparam logic [3:0] W_DST_HI    = 4'd9;
   localparam logic [3:0] W_DST_LO    = 4'd10;
   localparam logic [3:0] W_SRC_PORT  = 4'd11;
   localparam logic [3:0] W_DST_PORT  = 4'd12;
   localparam logic [3:0] W_UDP_LEN   = 4'd13;
   localparam logic [3:0] W_UDP_CSUM  = 4'd14;

   localparam logic [3:0] WORD_LAST = W_UDP_CSUM;

   // The checksum runs over the ten IPv4 header words.
   localparam logic [3:0] SUM_FIRST = W_VER_TOS;
   localparam logic [3:0] SUM_LAST  = W_DST_LO;

   localparam logic [15:0] FRAME_LEN_ADD = 16'd50;
   localparam logic [15:0] TOTAL_LEN_ADD = 16'd28;
   localparam logic [15:0] UDP_LEN_ADD   = 16'd8;
   localparam logic [15:0] ID_WORD       = 16'h01af;
   localparam logic [15:0] FLAGS_WORD    = 16'h4000;
   localparam logic [15:0] TTL_PROTO     = 16'h4011;
   localparam logic [15:0] UDP_CSUM_WORD = 16'h0000;
   localparam logic [15:0] SUM_SEED      = 16'hffff;
   localparam logic [15:0] CSUM_ZERO     = 16'h0000;

   // Job queue between front and back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] version_tos_word;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic [15:0] plen;
      logic [15:0] csum;
   } hdr_job_type;

   // Ones' complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

   // Value of one header word.
   function automatic logic [15:0] hdr_word(input logic [3:0] idx, input logic [15:0] plen,
                                            input cfg_type cfg, input logic [15:0] csum);
      logic [15:0] w;
      case (idx)
         W_FRAME_LEN: w = plen + FRAME_LEN_ADD;
         W_VER_TOS:   w = cfg.version_tos_word;
         W_TOTAL_LEN: w = plen + TOTAL_LEN_ADD;
         W_ID:        w = ID_WORD;
         W_FLAGS:     w = FLAGS_WORD;
         W_TTL_PROTO: w = TTL_PROTO;
         W_HDR_CSUM:  w = csum;
         W_SRC_HI:    w = cfg.source_address[31:16];
         W_SRC_LO:    w = cfg.source_address[15:0];
         W_DST_HI:    w = cfg.dest_address[31:16];
         W_DST_LO:    w = cfg.dest_address[15:0];
         W_SRC_PORT:  w = cfg.source_port;
         W_DST_PORT:  w = cfg.dest_port;
         W_UDP_LEN:   w = plen + UDP_LEN_ADD;
         default:     w = UDP_CSUM_WORD;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/ipv4_udp_header_builder.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header builder
// Turns a UDP payload length into the fifteen 16-bit framing header words.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_valid, req_stall, req_payload_len) takes one
// word per payload, and a word moves when valid is high and stall is low.
// For each accepted length that does not exceed max_payload the response
// channel (rsp_valid, rsp_stall, rsp_word_*) returns fifteen words in network
// order: frame length, the ten IPv4 header words with their checksum, and the
// four UDP header words. rsp_last marks word 14. An oversized length is taken
// and produces nothing.
// The front end sums the checksum over the ten IPv4 header words, one header
// word per cycle, and the back end sends one word per cycle while the
// receiver does not stall. A two-entry job queue lets the front end take and
// sum the next length while words still go out. When the receiver stalls,
// the output register holds its word, the back end waits, and once the
// queue fills the front end stalls the request channel.
// Reset empties the queue, stops any run in progress and returns the
// registers to their defaults: addresses and ports 0, version word 0x4500 and
// max_payload 1400. The user must write registers through csr_* only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ipv4_udp_header_builder
   import iuhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_payload_len,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_word_index,
   output logic [15:0]           rsp_word_value,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers; writes beyond the register list are ignored.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_ADDRESS:   cfg_in.source_address   = csr_data;
            CSR_DEST_ADDRESS:     cfg_in.dest_address     = csr_data;
            CSR_SOURCE_PORT:      cfg_in.source_port      = csr_data[15:0];
            CSR_DEST_PORT:        cfg_in.dest_port        = csr_data[15:0];
            CSR_VERSION_TOS_WORD: cfg_in.version_tos_word = csr_data[15:0];
            CSR_MAX_PAYLOAD:      cfg_in.max_payload      = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address   <= '0;
         cfg_ff.dest_address     <= '0;
         cfg_ff.source_port      <= '0;
         cfg_ff.dest_port        <= '0;
         cfg_ff.version_tos_word <= VERSION_TOS_RESET;
         cfg_ff.max_payload      <= MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end hands each checked length with its checksum to the queue.
   logic        push;
   hdr_job_type push_job;
   logic        q_ready;
   logic        q_valid;
   logic        pop;
   hdr_job_type head;

   iuhb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload_len (req_payload_len),
      .cfg             (cfg_ff),
      .push            (push),
      .job             (push_job),
      .q_ready         (q_ready)
   );

   iuhb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_ready  (q_ready),
      .pop      (pop),
      .q_valid  (q_valid),
      .head     (head)
   );

   // The back end drains the queue one header word per cycle while the receiver does not stall.
   iuhb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_last       (rsp_last)
   );

endmodule

// File: rtl/iuhb_front.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header builder front end
// Accepts payload lengths, drops oversized ones and sums the header checksum.
// ----------------------------------------------------------------------------
module iuhb_front
   import iuhb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_payload_len,
   input  cfg_type     cfg,
   output logic        push,
   output hdr_job_type job,
   input  logic        q_ready
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SUM  = 2'd1;
   localparam logic [1:0] F_HOLD = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] plen_ff, plen_in;
   logic        accept;

   assign req_stall = (state_ff == F_SUM) || ((state_ff == F_HOLD) && !q_ready);
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == F_HOLD) && q_ready;
   assign job.plen  = plen_ff;
   assign job.csum  = ~acc_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      plen_in  = plen_ff;
      case (state_ff)
         F_IDLE: begin
         end
         F_SUM: begin
            acc_in = ones_add(acc_ff, hdr_word(cnt_ff, plen_ff, cfg, CSUM_ZERO));
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == SUM_LAST) begin
               state_in = F_HOLD;
            end
         end
         F_HOLD: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      // An oversized payload is taken and dropped.
      if (accept && (req_payload_len <= cfg.max_payload)) begin
         state_in = F_SUM;
         plen_in  = req_payload_len;
         acc_in   = SUM_SEED;
         cnt_in   = SUM_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= SUM_FIRST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff  <= acc_in;
      plen_ff <= plen_in;
   end

`ifndef ASSERT_OFF
   a_sum_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_SUM) |-> ((cnt_ff >= SUM_FIRST) && (cnt_ff <= SUM_LAST)))
      else $error("checksum step count out of range");
`endif

endmodule

// File: rtl/iuhb_fifo.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header builder job queue
// Two-entry queue of checked lengths and checksums between front and back.
// ----------------------------------------------------------------------------
module iuhb_fifo
   import iuhb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hdr_job_type push_job,
   output logic        q_ready,
   input  logic        pop,
   output logic        q_valid,
   output hdr_job_type head
);

   localparam logic [QPTR_W-1:0] QPTR_ONE = QPTR_W'(1);
   localparam logic [QCNT_W-1:0] QCNT_ONE = QCNT_W'(1);
   localparam logic [QCNT_W-1:0] QCNT_MAX = QCNT_W'(QDEPTH);

   hdr_job_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_ready = (count_ff != QCNT_MAX);
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + QPTR_ONE) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + QPTR_ONE) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && !q_ready) |-> pop)
      else $error("job queue written while full");
`endif

endmodule

// File: rtl/iuhb_back.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header builder back end
// Steps through the fifteen header words of each queued job.
// ----------------------------------------------------------------------------
module iuhb_back
   import iuhb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  hdr_job_type head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_word_index,
   output logic [15:0] rsp_word_value,
   output logic        rsp_last
);

   logic        active_ff, active_in;
   logic [3:0]  idx_ff, idx_in;
   hdr_job_type cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        advance;
   logic        load_word;
   logic        run_end;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_word = active_ff && advance;
   assign run_end   = load_word && (idx_ff == WORD_LAST);
   assign pop       = q_valid && (!active_ff || run_end);

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = load_word || (rsp_valid_ff && rsp_stall);
      if (load_word) begin
         rsp_index_in = idx_ff;
         rsp_value_in = hdr_word(idx_ff, cur_ff.plen, cfg, cur_ff.csum);
         rsp_last_in  = (idx_ff == WORD_LAST);
         idx_in       = idx_ff + 4'd1;
      end
      if (run_end) begin
         active_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         idx_in    = W_FRAME_LEN;
         cur_in    = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= W_FRAME_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_word_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_index_ff == WORD_LAST)))
      else $error("last mark does not match word index");
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> active_ff)
      else $error("header run ended before its last word");
`endif

endmodule
